// ===== rtl/mwt_pkg.sv =====
`default_nettype none
package mwt_pkg;

  // event kinds on the output channel
  typedef enum logic [1:0] {
    EV_WORD  = 2'd0,
    EV_STYLE = 2'd1,
    EV_ALIGN = 2'd2
  } ev_kind_e;

  localparam int unsigned FieldW    = 25;
  localparam int unsigned MaxEvents = 8;

  localparam logic [7:0] EscReset = 8'd27;
  localparam logic [7:0] MarkB0   = 8'hEF;
  localparam logic [7:0] MarkB1   = 8'hBB;
  localparam logic [7:0] MarkB2   = 8'hBF;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  // alignment and style codes
  localparam logic [2:0] AlNone    = 3'd0;
  localparam logic [2:0] AlLeft    = 3'd1;
  localparam logic [2:0] AlRight   = 3'd2;
  localparam logic [2:0] AlCenter  = 3'd3;
  localparam logic [2:0] AlJustify = 3'd4;
  localparam logic [2:0] AlClose   = 3'd5;
  localparam logic [2:0] StRegular = 3'd0;
  localparam logic [2:0] StBold    = 3'd1;
  localparam logic [2:0] StItalic  = 3'd2;
  localparam logic [2:0] StBoldIt  = 3'd3;
  localparam logic [2:0] StHidden  = 3'd4;

  // one output word
  typedef struct packed {
    ev_kind_e          kind;
    logic [FieldW-1:0] rbegin;
    logic [FieldW-1:0] rend;
    logic [2:0]        attr;
  } ev_t;

  // alignment letter: start code, close code or none
  function automatic logic [2:0] align_code(input logic [7:0] c);
    logic [2:0] r;
    unique case (c)
      8'h4C: r = AlLeft;
      8'h52: r = AlRight;
      8'h43: r = AlCenter;
      8'h4A: r = AlJustify;
      8'h6C, 8'h72, 8'h63, 8'h6A: r = AlClose;
      default: r = AlNone;
    endcase
    return r;
  endfunction

  // style letter: bit 3 marks a style letter, low bits the new style
  function automatic logic [3:0] style_code(input logic [7:0] c);
    logic [3:0] r;
    unique case (c)
      8'h42: r = {1'b1, StBold};
      8'h49: r = {1'b1, StItalic};
      8'h58: r = {1'b1, StBoldIt};
      8'h48: r = {1'b1, StHidden};
      8'h62, 8'h69, 8'h78, 8'h68: r = {1'b1, StRegular};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/markup_word_tokenizer.sv =====
`default_nettype none
// channel   direction  handshake                 payload
// text      in         in_valid_i / in_stall_o   text_byte_i, end_of_text_i
// events    out        out_valid_o / out_stall_i event_kind_o, range_begin_o,
//                                                range_end_o, attribute_o, final_event_o
// config    in         cfg_we_i                  cfg_wdata_i (escape code)
//
// one byte is taken per cycle when its events fit; a byte decodes in the same
// cycle into up to eight events held in an eight-word output buffer.
// the buffer empties one word per cycle when the output is not stalled; the next
// byte can be taken as the last word leaves.
// reset clears all scan state and sets the escape code to 27.
// output stall holds the buffer; input stall rises while more than one word
// waits, or while the last word waits under output stall.
module markup_word_tokenizer
  import mwt_pkg::*;
#(
  parameter longint unsigned MAX_TEXT_BYTES = 64'd16777216
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic [7:0]        text_byte_i,
  input  wire logic              end_of_text_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [1:0]        event_kind_o,
  output      logic [FieldW-1:0] range_begin_o,
  output      logic [FieldW-1:0] range_end_o,
  output      logic [2:0]        attribute_o,
  output      logic              final_event_o,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i
);

  localparam int unsigned CW = $clog2(MAX_TEXT_BYTES + 64'd1);
  localparam logic [CW:0] MaxVal = (CW+1)'(MAX_TEXT_BYTES);

  typedef enum logic [1:0] {
    MODE_GAP   = 2'd0,
    MODE_SPACE = 2'd1,
    MODE_WORD  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [CW-1:0]  off;
    logic [CW-1:0]  wc;
    logic [2:0][7:0] h;
    logic [1:0]     hc;
    logic [1:0]     mode;
    logic [2:0]     st;
    logic [2:0]     al;
    logic [CW-1:0]  sfirst;
    logic [CW-1:0]  afirst;
    logic           sopen;
    logic           aopen;
    logic           md;
  } st_t;

  function automatic logic [CW-1:0] sat(input logic [CW-1:0] v, input logic [1:0] d);
    logic [CW:0] s;
    s = {1'b0, v} + (CW+1)'(d);
    return (s > MaxVal) ? MaxVal[CW-1:0] : s[CW-1:0];
  endfunction

  function automatic logic [FieldW-1:0] to_f(input logic [CW-1:0] v);
    logic [CW+FieldW-1:0] t;
    t = {{FieldW{1'b0}}, v};
    return t[FieldW-1:0];
  endfunction

  function automatic st_t pop(input st_t s, input logic [1:0] k);
    st_t r;
    r = s;
    if (k == 2'd1) begin
      r.h = {8'd0, s.h[2], s.h[1]};
    end else begin
      r.h = {8'd0, 8'd0, s.h[2]};
    end
    r.hc  = s.hc - k;
    r.off = sat(s.off, k);
    return r;
  endfunction

  st_t  s_q, s_d;
  logic [7:0] esc_q;
  ev_t  buf_q [MaxEvents];
  ev_t  ev_d  [MaxEvents];
  logic [3:0] rem_q, n_d;
  logic in_acc, out_acc;

  assign out_valid_o = (rem_q != 4'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = (rem_q > 4'd1) || ((rem_q == 4'd1) && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;

  assign event_kind_o  = buf_q[0].kind;
  assign range_begin_o = buf_q[0].rbegin;
  assign range_end_o   = buf_q[0].rend;
  assign attribute_o   = buf_q[0].attr;
  assign final_event_o = (rem_q == 4'd1);

  // decode one byte: push, mark check, drain up to three held bytes, flush
  always_comb begin
    st_t s;
    logic go, skip, fin;
    logic [7:0] c;
    logic [2:0] na, nst, acode;
    logic [3:0] scode;
    s    = s_q;
    n_d  = 4'd0;
    fin  = end_of_text_i;
    c    = 8'd0;
    skip = 1'b0;
    na   = AlNone;
    nst  = StRegular;
    acode = AlNone;
    scode = 4'd0;
    for (int i = 0; i < MaxEvents; i++) ev_d[i] = '0;
    if (s.hc == 2'd3) s.hc = 2'd2;
    s.h[s.hc] = text_byte_i;
    s.hc = s.hc + 2'd1;
    go = 1'b1;
    if (!s.md) begin
      if (s.hc < 2'd3 && !fin) begin
        go = 1'b0;
      end else begin
        s.md = 1'b1;
        if (s.hc == 2'd3 && s.h[0] == MarkB0 && s.h[1] == MarkB1 && s.h[2] == MarkB2) begin
          s.hc  = 2'd0;
          s.h   = '0;
          s.off = sat(s.off, 2'd3);
        end
      end
    end
    // drain held bytes
    for (int i = 0; i < 3; i++) begin
      if (go && s.hc != 2'd0) begin
        c    = s.h[0];
        skip = 1'b0;
        if (s.mode == MODE_SPACE) begin
          if (c == ChSpace) begin
            s = pop(s, 2'd1);
            skip = 1'b1;
          end else begin
            s.mode = MODE_GAP;
          end
        end
        if (!skip && c == esc_q) begin
          acode = align_code(s.h[1]);
          scode = style_code(s.h[1]);
          if (s.hc < 2'd2) begin
            if (!fin) begin
              go = 1'b0;
              skip = 1'b1;
            end
          end else if (acode != AlNone || scode[3]) begin
            s.mode = MODE_GAP;
            na  = (acode == AlClose) ? AlNone : ((acode != AlNone) ? acode : s.al);
            nst = scode[3] ? scode[2:0] : s.st;
            if (na != s.al) begin
              if (s.aopen && s.afirst < s.off) begin
                ev_d[n_d[2:0]] = '{EV_ALIGN, to_f(s.afirst), to_f(s.off), s.al};
                n_d = n_d + 4'd1;
              end
              s.al     = na;
              s.afirst = sat(s.off, 2'd2);
              s.aopen  = (na != AlNone);
            end
            if (nst != s.st) begin
              if (s.sopen && s.sfirst < s.wc) begin
                ev_d[n_d[2:0]] = '{EV_STYLE, to_f(s.sfirst), to_f(s.wc), s.st};
                n_d = n_d + 4'd1;
              end
              s.st     = nst;
              s.sfirst = s.wc;
              s.sopen  = (nst != StRegular);
            end
            s = pop(s, 2'd2);
            skip = 1'b1;
          end
        end
        if (!skip && s.mode != MODE_GAP) begin
          if (c == ChSpace || c == ChNl || c == ChTab) begin
            s.mode = MODE_GAP;
          end else begin
            s = pop(s, 2'd1);
            skip = 1'b1;
          end
        end
        if (!skip && c == ChCr) begin
          s = pop(s, 2'd1);
          skip = 1'b1;
        end
        if (!skip) begin
          ev_d[n_d[2:0]] = '{EV_WORD, to_f(s.off), '0, 3'd0};
          n_d = n_d + 4'd1;
          s.wc = sat(s.wc, 2'd1);
          if (c == ChNl) begin
            if (s.aopen) begin
              ev_d[n_d[2:0]] = '{EV_ALIGN, to_f(s.afirst), to_f(sat(s.off, 2'd1)), s.al};
              n_d = n_d + 4'd1;
              s.al    = AlNone;
              s.aopen = 1'b0;
            end
            s.mode = MODE_GAP;
          end else if (c == ChTab) begin
            s.mode = MODE_GAP;
          end else if (c == ChSpace) begin
            s.mode = MODE_SPACE;
          end else begin
            s.mode = MODE_WORD;
          end
          s = pop(s, 2'd1);
        end
      end
    end
    // end of text: flush open ranges and restart
    if (fin) begin
      if (s.sopen && s.sfirst < s.wc) begin
        ev_d[n_d[2:0]] = '{EV_STYLE, to_f(s.sfirst), to_f(s.wc), s.st};
        n_d = n_d + 4'd1;
      end
      if (s.aopen && s.afirst < s.off) begin
        ev_d[n_d[2:0]] = '{EV_ALIGN, to_f(s.afirst), to_f(s.off), s.al};
        n_d = n_d + 4'd1;
      end
      s = '0;
    end
    s_d = s;
  end

  // scan state, escape register and buffer count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q   <= '0;
      esc_q <= EscReset;
      rem_q <= 4'd0;
    end else begin
      if (cfg_we_i) esc_q <= cfg_wdata_i;
      if (in_acc) begin
        s_q   <= s_d;
        rem_q <= n_d;
      end else if (out_acc) begin
        rem_q <= rem_q - 4'd1;
      end
    end
  end

  // event buffer, loaded with a taken byte's events, shifts one word per taken event
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MaxEvents; i++) buf_q[i] <= ev_d[i];
    end else if (out_acc) begin
      for (int i = 0; i < MaxEvents - 1; i++) buf_q[i] <= buf_q[i+1];
    end
  end

  // checks
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (rem_q <= 4'd1)) else $error("byte taken over pending events");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 4'd8) else $error("event count out of range");
  a_fin_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_text_i) |=> (s_q.hc == 2'd0 && s_q.off == '0 && !s_q.md))
    else $error("scan state not cleared after end of text");
  a_style_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_q.sopen |-> (s_q.st != StRegular)) else $error("open style range is regular");

endmodule
`default_nettype wire
